// ----- rtl/elevator_nearest_floor_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-floor elevator controller
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_NEAREST_FLOOR_CONTROLLER_ASSERT_SVH
`define ELEVATOR_NEAREST_FLOOR_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define NFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nfc_pkg.sv -----
// ----------------------------------------------------------------------------
// nfc_pkg
// Shared constants and types of the nearest-floor elevator controller.
// ----------------------------------------------------------------------------
package nfc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FLOOR_BITS  = 6;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int MODE_BITS   = 2;

  localparam logic [MODE_BITS-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MOVING = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DOOR   = 2'd2;

  // first field in the highest bits, last field in the lowest bits
  typedef struct packed {
    logic [CNT_BITS-1:0]   pending_count;
    logic                  request_dropped;
    logic                  arrived;
    logic [FLOOR_BITS-1:0] car_floor;
    logic [MODE_BITS-1:0]  car_state;
  } result_t;

  localparam int RES_BITS       = $bits(result_t);
  localparam int OUT_TDATA_BITS = ((RES_BITS + 7) / 8) * 8;
  localparam int IN_TDATA_BITS  = ((FLOOR_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [FLOOR_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
  } mem_req_t;

endpackage

// ----- rtl/nfc_ram.sv -----
// ----------------------------------------------------------------------------
// nfc_ram
// Request store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfc_ram (
  input  logic                          clk,
  input  nfc_pkg::mem_req_t             req,
  output logic [nfc_pkg::FLOOR_BITS-1:0] rd_data
);
  import nfc_pkg::*;

  logic [FLOOR_BITS-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- rtl/nfc_core.sv -----
// ----------------------------------------------------------------------------
// nfc_core
// Sequencer: appends requests, runs the car mode step, and on a serve does a
// nearest-floor scan pass and a compaction pass over the request store.
// ----------------------------------------------------------------------------
module nfc_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [nfc_pkg::FLOOR_BITS-1:0] in_floor,
  output logic                           res_valid,
  input  logic                           res_ready,
  output nfc_pkg::result_t               res,
  output nfc_pkg::mem_req_t              mreq,
  input  logic [nfc_pkg::FLOOR_BITS-1:0] rd_data
);
  import nfc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COMP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state, state_next;
  logic [MODE_BITS-1:0]  mode, mode_next;
  logic [FLOOR_BITS-1:0] position, position_next;
  logic [CNT_BITS-1:0]   total, total_next;
  logic [CNT_BITS-1:0]   rd_idx, rd_idx_next;
  logic                  rd_pend, rd_pend_next;
  logic [CNT_BITS-1:0]   kept, kept_next;
  logic [FLOOR_BITS-1:0] best, best_next;
  logic [FLOOR_BITS-1:0] best_d, best_d_next;
  logic                  have_best, have_best_next;
  logic                  arrived, arrived_next;
  logic                  dropped, dropped_next;

  logic                  append;
  logic [CNT_BITS-1:0]   tot_new;
  logic [FLOOR_BITS-1:0] gap;
  logic                  pass_end;

  assign gap      = (position > rd_data) ? (position - rd_data) : (rd_data - position);
  assign pass_end = (rd_idx == total) && !rd_pend;
  assign append   = !in_func && (total != CNT_BITS'(QUEUE_DEPTH));
  assign tot_new  = total + CNT_BITS'(append);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.car_state       = mode;
    res.car_floor       = position;
    res.arrived         = arrived;
    res.request_dropped = dropped;
    res.pending_count   = total;
  end

  // Compaction writes entry kept while reading entry rd_idx; kept never
  // passes the entry in flight, so a pass needs no forwarding.
  always_comb begin
    state_next     = state;
    mode_next      = mode;
    position_next  = position;
    total_next     = total;
    rd_idx_next    = rd_idx;
    rd_pend_next   = rd_pend;
    kept_next      = kept;
    best_next      = best;
    best_d_next    = best_d;
    have_best_next = have_best;
    arrived_next   = arrived;
    dropped_next   = dropped;
    mreq           = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dropped_next = !in_func && !append;
          arrived_next = 1'b0;
          total_next   = tot_new;
          if (append) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = total[IDX_BITS-1:0];
            mreq.wr_data = in_floor;
          end
          state_next = S_DONE;
          unique case (mode)
            MODE_MOVING: begin
              if (tot_new != '0) begin
                state_next     = S_SCAN;
                rd_idx_next    = '0;
                rd_pend_next   = 1'b0;
                have_best_next = 1'b0;
              end else begin
                mode_next = MODE_DOOR;
              end
            end
            MODE_DOOR: mode_next = (tot_new == '0) ? MODE_IDLE : MODE_MOVING;
            default:   mode_next = (tot_new != '0) ? MODE_MOVING : MODE_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        rd_pend_next = 1'b0;
        if (rd_idx != total) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = rd_idx[IDX_BITS-1:0];
          rd_idx_next  = rd_idx + 1'b1;
          rd_pend_next = 1'b1;
        end
        // strict less-than keeps the earliest entry on ties
        if (rd_pend && (!have_best || (gap < best_d))) begin
          best_next      = rd_data;
          best_d_next    = gap;
          have_best_next = 1'b1;
        end
        if (pass_end) begin
          state_next  = S_COMP;
          rd_idx_next = '0;
          kept_next   = '0;
        end
      end
      S_COMP: begin
        rd_pend_next = 1'b0;
        if (rd_idx != total) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = rd_idx[IDX_BITS-1:0];
          rd_idx_next  = rd_idx + 1'b1;
          rd_pend_next = 1'b1;
        end
        if (rd_pend && (rd_data != best)) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = kept[IDX_BITS-1:0];
          mreq.wr_data = rd_data;
          kept_next    = kept + 1'b1;
        end
        if (pass_end) begin
          total_next    = kept;
          position_next = best;
          mode_next     = MODE_DOOR;
          arrived_next  = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= MODE_IDLE;
      position <= '0;
      total    <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      position <= position_next;
      total    <= total_next;
      rd_pend  <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx    <= rd_idx_next;
    kept      <= kept_next;
    best      <= best_next;
    best_d    <= best_d_next;
    have_best <= have_best_next;
    arrived   <= arrived_next;
    dropped   <= dropped_next;
  end

endmodule

// ----- rtl/elevator_nearest_floor_controller.sv -----
// ----------------------------------------------------------------------------
// elevator_nearest_floor_controller
// Single-car nearest-floor-first controller with a stored request list.
// ----------------------------------------------------------------------------
// Each input beat (tuser = func, tdata = floor) gives exactly one output beat.
// A beat that does not serve a floor goes from accept straight to the result;
// a serving step's length is set by the request memory's single read port,
// which is walked once to find the nearest floor and once to compact the list.
// The result sits in an output register, so the next beat is taken while it
// waits.
module elevator_nearest_floor_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [nfc_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // [5:0] floor, rest zero
  input  logic [0:0]                          s_tuser,  // [0] func
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] car_state, [7:2] car_floor, [8] arrived, [9] request_dropped,
  // [14:10] pending_count, rest zero
  output logic [nfc_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
  import nfc_pkg::*;

  mem_req_t              mreq;
  logic [FLOOR_BITS-1:0] rd_data;
  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  result_t               out_res;

  nfc_ram u_ram (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  nfc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser[0]),
    .in_floor  (s_tdata[FLOOR_BITS-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mreq      (mreq),
    .rd_data   (rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = OUT_TDATA_BITS'(out_res);

endmodule

// ----- rtl/nfc_checker.sv -----
// ----------------------------------------------------------------------------
// nfc_checker
// Port-level checks of the nearest-floor elevator controller.
// ----------------------------------------------------------------------------
`include "elevator_nearest_floor_controller_assert.svh"

module nfc_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [nfc_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
  import nfc_pkg::*;

  result_t out_res;
  assign out_res = result_t'(m_tdata[RES_BITS-1:0]);

  `NFC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output beat dropped while stalled")
  `NFC_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled beat changed")
  `NFC_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
  `NFC_ASSERT_IMP(a_arrive_door, m_tvalid && out_res.arrived, out_res.car_state == MODE_DOOR, "arrival without door open")
  `NFC_ASSERT_IMP(a_count_range, m_tvalid, out_res.pending_count <= CNT_BITS'(QUEUE_DEPTH), "pending count above depth")

endmodule

bind elevator_nearest_floor_controller nfc_checker u_nfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
